// File: rtl/core/owc_pkg.sv
// Shared types, codes and the CRC-8 step for the scratchpad checker.
package owc_pkg;

  localparam logic [7:0] CrcPoly = 8'h8C;
  localparam logic [15:0] PowerOnRaw = 16'h0550;
  localparam logic [3:0] FrameDataBytes = 4'd8;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CRC_BAD   = 2'd1,
    ST_POWER_ON  = 2'd2,
    ST_XFER_FAIL = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       transfer_failed;
  } byte_item_t;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic [1:0]         status;
  } result_item_t;

  typedef struct packed {
    logic         hit;
    result_item_t item;
  } frame_res_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                             input logic [7:0] data);
    logic [7:0] crc;
    logic [7:0] d;
    logic       fb;
    crc = crc_in;
    d = data;
    for (int i = 0; i < 8; i++) begin
      fb = crc[0] ^ d[0];
      crc = {1'b0, crc[7:1]};
      if (fb) begin
        crc = crc ^ CrcPoly;
      end
      d = {1'b0, d[7:1]};
    end
    return crc;
  endfunction

endpackage

// File: rtl/core/onewire_scratchpad_checker.sv
// Top level of the scratchpad checker: input register, frame logic, result register.
//
// Accepts one scratchpad byte per clock cycle while byte_stall is low, byte 0 first, and
// gives one result after the ninth byte or at once on a failed transfer. Each transaction
// passes the input register and then the result register before result_valid rises. The
// result register lets a new byte in while a result waits to be taken.
module onewire_scratchpad_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  owc_pkg::byte_item_t   byte_item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output owc_pkg::result_item_t result_item
);
  import owc_pkg::*;

  logic       s1_valid;
  byte_item_t s1_item;
  frame_res_t res;
  logic       advance;

  assign advance = s1_valid && (!res.hit || !result_valid || !result_stall);
  assign byte_stall = s1_valid && !advance;

  owc_frame u_frame (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (s1_item),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      s1_item <= byte_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && res.hit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.hit) begin
      result_item <= res.item;
    end
  end

endmodule

// File: rtl/core/owc_frame.sv
// Frame state of the scratchpad checker: CRC, byte count, temperature bytes.
module owc_frame (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  owc_pkg::byte_item_t item,
  output owc_pkg::frame_res_t res
);
  import owc_pkg::*;

  logic [7:0]  running_crc;
  logic [3:0]  byte_position;
  logic [7:0]  temp_low_byte;
  logic [7:0]  temp_high_byte;
  logic [7:0]  running_crc_next;
  logic [15:0] raw;
  logic        check_byte;
  status_t     status;

  assign raw = {temp_high_byte, temp_low_byte};
  assign check_byte = byte_position >= FrameDataBytes;
  assign running_crc_next = crc8_update(running_crc, item.data_byte);

  always_comb begin
    status = ST_OK;
    res.hit = 1'b0;
    if (item.transfer_failed) begin
      status = ST_XFER_FAIL;
      res.hit = 1'b1;
    end else if (check_byte) begin
      res.hit = 1'b1;
      if (running_crc != item.data_byte) begin
        status = ST_CRC_BAD;
      end else if (raw == PowerOnRaw) begin
        status = ST_POWER_ON;
      end
    end
    res.item.status = status;
    res.item.temperature = (status == ST_OK) ? $signed(raw) : 16'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= '0;
      byte_position <= '0;
      temp_low_byte <= '0;
      temp_high_byte <= '0;
    end else if (step) begin
      if (item.transfer_failed || check_byte) begin
        running_crc <= '0;
        byte_position <= '0;
      end else begin
        if (byte_position == 4'd0) begin
          temp_low_byte <= item.data_byte;
        end else if (byte_position == 4'd1) begin
          temp_high_byte <= item.data_byte;
        end
        running_crc <= running_crc_next;
        byte_position <= byte_position + 4'd1;
      end
    end
  end

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= FrameDataBytes)
    else $error("byte count beyond frame length");
  a_restart: assert property (@(posedge clk) disable iff (rst)
    step && res.hit |=> byte_position == 4'd0 && running_crc == 8'd0)
    else $error("frame did not restart after result");
  a_fail_result: assert property (@(posedge clk) disable iff (rst)
    step && item.transfer_failed |-> res.hit && res.item.status == ST_XFER_FAIL)
    else $error("transfer failure gave no failed result");
  a_temp_zero: assert property (@(posedge clk) disable iff (rst)
    step && res.hit && res.item.status != ST_OK |-> res.item.temperature == 16'sd0)
    else $error("temperature not cleared on bad status");
`endif

endmodule

// File: tb/tb_onewire_scratchpad_checker.sv
// Self-checking testbench for the scratchpad checker: directed and random frames vs. a predictor.
`timescale 1ns / 100ps

module tb_onewire_scratchpad_checker;
  import owc_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic [7:0]         data;
    logic               fail;
    logic               crc_fill;
    logic               typed;
    logic signed [15:0] temp;
    status_t            st;
  } frame_row_t;

  localparam frame_row_t FrameRows [0:22] = '{
    '{8'hFF, 1'b1, 1'b0, 1'b1, 16'sd0, ST_XFER_FAIL},
    '{8'h00, 1'b0, 1'b0, 1'b0, 16'sd0, ST_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, 16'sd0, ST_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, 16'sd0, ST_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, 16'sd0, ST_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, 16'sd0, ST_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, 16'sd0, ST_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, 16'sd0, ST_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, 16'sd0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b1, 16'sd0, ST_CRC_BAD},
    '{8'h50, 1'b0, 1'b0, 1'b0, 16'sd0, ST_OK},
    '{8'h05, 1'b0, 1'b0, 1'b0, 16'sd0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 16'sd0, ST_OK},
    '{8'h7F, 1'b0, 1'b0, 1'b0, 16'sd0, ST_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, 16'sd0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 16'sd0, ST_OK},
    '{8'h0C, 1'b0, 1'b0, 1'b0, 16'sd0, ST_OK},
    '{8'h10, 1'b0, 1'b0, 1'b0, 16'sd0, ST_OK},
    '{8'h00, 1'b0, 1'b1, 1'b1, 16'sd0, ST_POWER_ON},
    '{8'h12, 1'b0, 1'b0, 1'b0, 16'sd0, ST_OK},
    '{8'h34, 1'b0, 1'b0, 1'b0, 16'sd0, ST_OK},
    '{8'h56, 1'b0, 1'b0, 1'b0, 16'sd0, ST_OK},
    '{8'h00, 1'b1, 1'b0, 1'b1, 16'sd0, ST_XFER_FAIL}
  };

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         byte_valid = 1'b0;
  logic         byte_stall;
  byte_item_t   byte_item = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_item_t result_item;

  logic [7:0] crc_acc = '0;
  logic [3:0] bytes_seen = '0;
  logic [7:0] temp_lo = '0;
  logic [7:0] temp_hi = '0;

  result_item_t readings_due[$];
  int           mismatches = 0;
  int           items_sent = 0;
  int           cycle_cnt = 0;
  logic         idle_on = 1'b0;
  int           hold_tag = 0;
  int           hold_seen = 0;
  int           hold_cnt = 0;

  onewire_scratchpad_checker dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] maxim_crc_byte(input logic [7:0] c, input logic [7:0] d);
    logic [7:0] r;
    r = c ^ d;
    repeat (8) r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    return r;
  endfunction

  function automatic logic scratchpad_step(input byte_item_t it, output result_item_t res);
    logic [15:0] raw;
    res = '0;
    if (it.transfer_failed) begin
      crc_acc = '0;
      bytes_seen = '0;
      res.status = ST_XFER_FAIL;
      return 1'b1;
    end
    if (bytes_seen < FrameDataBytes) begin
      if (bytes_seen == 4'd0) begin
        temp_lo = it.data_byte;
      end else if (bytes_seen == 4'd1) begin
        temp_hi = it.data_byte;
      end
      crc_acc = maxim_crc_byte(crc_acc, it.data_byte);
      bytes_seen = bytes_seen + 4'd1;
      return 1'b0;
    end
    raw = {temp_hi, temp_lo};
    if (crc_acc != it.data_byte) begin
      res.status = ST_CRC_BAD;
    end else if (raw == PowerOnRaw) begin
      res.status = ST_POWER_ON;
    end else begin
      res.status = ST_OK;
      res.temperature = raw;
    end
    crc_acc = '0;
    bytes_seen = '0;
    return 1'b1;
  endfunction

  task automatic feed_byte(input logic [7:0] data, input logic fail, input logic typed,
                           input result_item_t typed_res);
    byte_item_t   it;
    result_item_t res;
    logic         hit;
    it.data_byte = data;
    it.transfer_failed = fail;
    if (idle_on && $urandom_range(99) < 32) begin
      byte_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 32);
    end
    byte_valid <= 1'b1;
    byte_item <= it;
    do @(posedge clk); while (byte_stall);
    hit = scratchpad_step(it, res);
    if (typed) begin
      readings_due.push_back(typed_res);
    end else if (hit) begin
      readings_due.push_back(res);
    end
    items_sent++;
  endtask

  task automatic drain_readings();
    byte_valid <= 1'b0;
    do @(posedge clk); while (readings_due.size() != 0);
  endtask

  task automatic random_burst();
    logic [7:0] fb [0:8];
    logic [7:0] c;
    int         abort_at;
    int         n;
    if ($urandom_range(99) < 8) begin
      n = $urandom_range(12, 1);
      for (int i = 0; i < n; i++) begin
        feed_byte(8'($urandom), $urandom_range(99) < 5, 1'b0, '0);
      end
      // resync to a frame boundary
      feed_byte(8'($urandom), 1'b1, 1'b0, '0);
    end else begin
      case ($urandom_range(9))
        0: {fb[1], fb[0]} = 16'h8000;
        1: {fb[1], fb[0]} = 16'h7FFF;
        2: {fb[1], fb[0]} = PowerOnRaw;
        3: {fb[1], fb[0]} = 16'hFFFF;
        4: {fb[1], fb[0]} = 16'h0000;
        default: {fb[1], fb[0]} = 16'($urandom);
      endcase
      for (int i = 2; i < 8; i++) fb[i] = 8'($urandom);
      c = '0;
      for (int i = 0; i < 8; i++) c = maxim_crc_byte(c, fb[i]);
      fb[8] = ($urandom_range(99) < 20) ? (c ^ (8'h01 << $urandom_range(7))) : c;
      abort_at = ($urandom_range(99) < 8) ? $urandom_range(8) : -1;
      for (int i = 0; i < 9; i++) begin
        if (i == abort_at) begin
          feed_byte(8'($urandom), 1'b1, 1'b0, '0);
          break;
        end
        feed_byte(fb[i], 1'b0, 1'b0, '0);
      end
    end
  endtask

  task automatic check_reading(input result_item_t got);
    result_item_t want;
    if (readings_due.size() == 0) begin
      $display("%0t: unexpected transaction: temperature %0d status %0d",
               $time, got.temperature, got.status);
      mismatches++;
    end else begin
      want = readings_due.pop_front();
      if (got.temperature !== want.temperature) begin
        $display("%0t: temperature mismatch: expected %0d actual %0d",
                 $time, want.temperature, got.temperature);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, want.status, got.status);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      check_reading(result_item);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_seen <= 0;
      hold_cnt <= 0;
    end else if (hold_seen != hold_tag) begin
      hold_seen <= hold_tag;
      hold_cnt <= HoldCycles;
      result_stall <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= idle_on && ($urandom_range(99) < 32);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    result_item_t typed_res;
    logic [7:0]   data;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    foreach (FrameRows[i]) begin
      typed_res.temperature = FrameRows[i].temp;
      typed_res.status = FrameRows[i].st;
      data = FrameRows[i].crc_fill ? crc_acc : FrameRows[i].data;
      feed_byte(data, FrameRows[i].fail, FrameRows[i].typed, typed_res);
    end
    drain_readings();

    while (items_sent < 140) random_burst();
    idle_on = 1'b0;
    while (items_sent < 230) random_burst();
    idle_on = 1'b1;
    hold_tag <= hold_tag + 1;
    while (items_sent < 310) random_burst();
    drain_readings();
    while (items_sent < 470) random_burst();

    drain_readings();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
